// ===== rtl/core/cfss_pkg.sv =====
// shared types and constants for the capped fair share split
package cfss_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_PASS,
    ST_PASS_APPLY,
    ST_FILL_DIV,
    ST_FILL_WAIT,
    ST_FILL_APPLY,
    ST_EMIT
  } cfss_state_t;

  typedef enum logic [1:0] {
    DIV_PASS,
    DIV_FILL,
    DIV_IDLE
  } cfss_div_use_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic div_start;
    logic div_rank;
    logic pass_first;
    logic pass_step;
    logic pass_drop;
    logic fill_first;
    logic fill_step;
    logic fill_apply;
    logic emit_first;
    logic emit_step;
    logic finish;
  } cfss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic cur_active;
    logic cur_now;
    logic pass_end;
    logic dropped;
    logic left_zero;
    logic fill_end;
    logic emit_end;
  } cfss_status_t;

endpackage

// ===== rtl/core/cfss_div.sv =====
// iterative signed divider, truncating toward zero, one quotient bit a cycle
module cfss_div import cfss_pkg::*; #(
  parameter int CW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] dividend,
  input  logic [CW-1:0]      divisor,
  output logic               done,
  output logic signed [16:0] quotient
);

  localparam int QW = 17;

  logic [QW-1:0]   quo;
  logic [CW:0]     rem;
  logic [CW-1:0]   dsr;
  logic            neg;
  logic [4:0]      cnt;
  logic            run;
  logic [CW:0]     trial;
  logic [QW-1:0]   mag;

  assign mag   = dividend[16] ? (~dividend + 17'd1) : dividend;
  assign trial = {rem[CW-1:0], quo[QW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'(QW);
        quo <= mag;
        rem <= '0;
        dsr <= divisor;
        neg <= dividend[16];
      end else if (run) begin
        if (!trial[CW]) begin
          rem <= trial;
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= {rem[CW-1:0], quo[QW-1]};
          quo <= {quo[QW-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);

endmodule

// ===== rtl/core/cfss_datapath.sv =====
// holder stores, running remainder, share and result formation
module cfss_datapath import cfss_pkg::*; #(
  parameter int MAX_HOLDERS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  cfss_cmd_t          cmd,
  output cfss_status_t       stat,
  input  logic [7:0]         holder_amount,
  input  logic [7:0]         holder_free,
  input  logic signed [15:0] total_change,
  input  logic [7:0]         resource_kind,
  output logic signed [8:0]  holder_change,
  output logic [7:0]         resource_kind_out,
  output logic signed [12:0] applied_total,
  output logic               last_result
);

  logic [7:0]         amount_mem [MAX_HOLDERS];
  logic [7:0]         free_mem [MAX_HOLDERS];
  logic signed [8:0]  change_mem [MAX_HOLDERS];
  logic [MAX_HOLDERS-1:0] active;
  logic [CW-1:0]      count;
  logic [CW-1:0]      left;
  logic [CW-1:0]      rank;
  logic [IW-1:0]      idx;
  logic signed [16:0] remaining;
  logic signed [16:0] delta;
  logic signed [16:0] share;
  logic               dropped;
  logic [7:0]         kind;

  logic               div_start;
  logic signed [16:0] div_num;
  logic [CW-1:0]      div_den;
  logic               div_done;
  logic signed [16:0] div_q;

  logic [7:0]         cur_amt;
  logic [7:0]         cur_free;
  logic signed [16:0] cur_d;
  logic signed [8:0]  applied;
  logic               now;
  logic [CW-1:0]      idx_ext;

  assign idx_ext = CW'(idx);
  assign cur_amt  = amount_mem[idx];
  assign cur_free = free_mem[idx];

  // d applied to the current holder, clamped by room or amount
  always_comb begin
    if (!cur_d[16]) begin
      applied = (cur_d < $signed({9'd0, cur_free})) ? cur_d[8:0] : $signed({1'b0, cur_free});
    end else begin
      applied = (cur_d > -$signed({9'd0, cur_amt})) ? cur_d[8:0]
                                                    : -$signed({1'b0, cur_amt});
    end
  end

  always_comb begin
    if (remaining > 0) begin
      now = $signed({9'd0, cur_free}) <= share;
    end else begin
      now = $signed({9'd0, cur_amt}) <= -share;
    end
  end

  assign cur_d = cmd.fill_apply ? div_q : share;

  assign div_start = cmd.div_start;
  assign div_num   = remaining;
  assign div_den   = cmd.div_rank ? rank : left;

  cfss_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && count < CW'(MAX_HOLDERS)) begin
      amount_mem[count[IW-1:0]] <= holder_amount;
      free_mem[count[IW-1:0]]   <= holder_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      active    <= '0;
      left      <= '0;
      rank      <= '0;
      idx       <= '0;
      remaining <= '0;
      share     <= '0;
      dropped   <= 1'b0;
      for (int i = 0; i < MAX_HOLDERS; i++) change_mem[i] <= '0;
    end else begin
      // total and kind of the closing word are the ones kept
      if (cmd.load) begin
        delta <= 17'(total_change);
        kind  <= resource_kind;
      end
      if (cmd.load && count < CW'(MAX_HOLDERS)) count <= count + CW'(1);
      if (cmd.init) begin
        remaining <= delta;
        left      <= count;
        for (int i = 0; i < MAX_HOLDERS; i++) begin
          active[i]     <= (CW'(i) < count);
          change_mem[i] <= '0;
        end
      end
      if (div_done && !(cmd.fill_first || cmd.fill_step || cmd.fill_apply)) share <= div_q;
      if (cmd.pass_first) begin
        idx     <= '0;
        dropped <= 1'b0;
      end
      if (cmd.pass_drop) begin
        change_mem[idx] <= applied;
        remaining       <= remaining - 17'(applied);
        active[idx]     <= 1'b0;
        left            <= left - CW'(1);
        dropped         <= 1'b1;
      end
      if (cmd.pass_step) idx <= idx + IW'(1);
      if (cmd.fill_first) begin
        idx  <= IW'(count - CW'(1));
        rank <= left;
      end
      if (cmd.fill_apply) begin
        if (active[idx]) begin
          change_mem[idx] <= applied;
          remaining       <= remaining - 17'(applied);
          rank            <= rank - CW'(1);
        end
      end
      if (cmd.fill_step) idx <= idx - IW'(1);
      if (cmd.emit_first) idx <= '0;
      if (cmd.emit_step) idx <= idx + IW'(1);
      if (cmd.finish) count <= '0;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.cur_active = active[idx];
  assign stat.cur_now    = now;
  assign stat.pass_end   = (idx_ext + CW'(1)) >= count;
  assign stat.dropped    = dropped;
  assign stat.left_zero  = (left == '0);
  assign stat.fill_end   = (idx == '0);
  assign stat.emit_end   = (idx_ext + CW'(1)) >= count;

  assign holder_change     = change_mem[idx];
  assign resource_kind_out = kind;
  assign applied_total     = 13'(delta - remaining);
  assign last_result       = (idx_ext + CW'(1)) == count;

endmodule

// ===== rtl/core/cfss_ctrl.sv =====
// sequencer for load, clamping passes, even fill and result emission
module cfss_ctrl import cfss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         last_holder,
  output logic         busy,
  output logic         strobe,
  output cfss_cmd_t    cmd,
  input  cfss_status_t stat
);

  cfss_state_t state, state_next;
  logic        in_fill, in_fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      in_fill <= 1'b0;
    end else begin
      state   <= state_next;
      in_fill <= in_fill_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_fill_next = in_fill;
    cmd          = '0;
    busy         = (state != ST_LOAD);
    strobe       = 1'b0;
    case (state)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_holder) state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // empty set gives a zero divisor; the quotient is unused then
        cmd.div_start = 1'b1;
        cmd.pass_first = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) state_next = ST_PASS;
      end
      ST_PASS: begin
        if (stat.left_zero) begin
          state_next = ST_EMIT;
          cmd.emit_first = 1'b1;
        end else if (stat.cur_active && stat.cur_now) begin
          cmd.pass_drop = 1'b1;
          state_next    = ST_PASS_APPLY;
        end else if (stat.pass_end) begin
          if (stat.dropped) begin
            cmd.pass_first = 1'b1;
            cmd.div_start  = 1'b1;
            state_next     = ST_DIV_WAIT;
          end else begin
            cmd.fill_first = 1'b1;
            state_next     = ST_FILL_DIV;
          end
        end else begin
          cmd.pass_step = 1'b1;
        end
      end
      ST_PASS_APPLY: begin
        // share recomputed at once after each drop that leaves holders active
        if (stat.left_zero) begin
          cmd.emit_first = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_FILL_WAIT;
          in_fill_next  = 1'b0;
        end
      end
      ST_FILL_DIV: begin
        if (stat.cur_active) begin
          cmd.div_start = 1'b1;
          cmd.div_rank  = 1'b1;
          cmd.fill_step = 1'b0;
          in_fill_next  = 1'b1;
          state_next    = ST_FILL_WAIT;
        end else if (stat.fill_end) begin
          cmd.emit_first = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_FILL_WAIT: begin
        if (stat.div_done) begin
          if (in_fill) begin
            cmd.fill_apply = 1'b1;
            state_next     = ST_FILL_APPLY;
          end else if (stat.pass_end) begin
            state_next = ST_PASS;
          end else begin
            cmd.pass_step = 1'b1;
            state_next    = ST_PASS;
          end
        end
      end
      ST_FILL_APPLY: begin
        if (stat.fill_end) begin
          cmd.emit_first = 1'b1;
          state_next     = ST_EMIT;
        end else begin
          cmd.fill_step = 1'b1;
          state_next    = ST_FILL_DIV;
        end
      end
      ST_EMIT: begin
        if (stat.pass_end && !stat.emit_end) begin
          state_next = ST_EMIT;
        end
        strobe = 1'b1;
        if (stat.emit_end) begin
          cmd.finish = 1'b1;
          state_next = ST_LOAD;
        end else begin
          cmd.emit_step = 1'b1;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ===== rtl/core/capped_fair_share_split_top.sv =====
// top level of the capped fair share split
// holder words load one a cycle while start is high and busy is low; the last word starts the split
// the split time grows with passes, holders, drops and active holders,
// set largely by the serial divider shared by every share update
// then one result word a cycle per holder, in load order; the receiver cannot stall
// rst (synchronous) empties the set and returns to loading
module capped_fair_share_split_top import cfss_pkg::*; #(
  parameter int MAX_HOLDERS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         holder_amount,
  input  logic [7:0]         holder_free,
  input  logic signed [15:0] total_change,
  input  logic [7:0]         resource_kind,
  input  logic               last_holder,
  output logic               strobe,
  output logic signed [8:0]  holder_change,
  output logic [7:0]         resource_kind_out,
  output logic signed [12:0] applied_total,
  output logic               last_result
);

  localparam int IW = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
  localparam int CW = $clog2(MAX_HOLDERS + 1);

  cfss_cmd_t    cmd;
  cfss_status_t stat;

  cfss_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_holder (last_holder),
    .busy        (busy),
    .strobe      (strobe),
    .cmd         (cmd),
    .stat        (stat)
  );

  cfss_datapath #(
    .MAX_HOLDERS (MAX_HOLDERS),
    .IW          (IW),
    .CW          (CW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .holder_amount     (holder_amount),
    .holder_free       (holder_free),
    .total_change      (total_change),
    .resource_kind     (resource_kind),
    .holder_change     (holder_change),
    .resource_kind_out (resource_kind_out),
    .applied_total     (applied_total),
    .last_result       (last_result)
  );

endmodule
